@@ rtl/lru_block_buffer_cache_core_defines.svh @@
// Assertion macros for the buffer cache RTL.
// Assumes the including module has ports named clock and reset.
`ifndef LRU_BLOCK_BUFFER_CACHE_CORE_DEFINES_SVH
`define LRU_BLOCK_BUFFER_CACHE_CORE_DEFINES_SVH

// same-cycle implication
`define LBC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LBC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/lbc_pkg.sv @@
// Types and constants for the LRU block buffer cache.
// No dependencies.
`default_nettype none
package lbc_pkg;

   localparam int DEVICE_W  = 8;
   localparam int BLOCK_W   = 32;
   localparam int SLOT_IN_W = 5;
   localparam int COUNT_W   = 8;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

   typedef enum logic [1:0] {
      MODE_GET     = 2'd0,
      MODE_RELEASE = 2'd1,
      MODE_PIN     = 2'd2,
      MODE_UNPIN   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NO_FREE   = 2'd1,
      STATUS_UNDERFLOW = 2'd2,
      STATUS_OVERFLOW  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic load_req;
      logic search;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } stat_type;

endpackage
`default_nettype wire

@@ rtl/lbc_ctrl.sv @@
// Sequencer for the buffer cache: request capture, search, update.
// Depends on lbc_pkg and the assertion macro header.
`default_nettype none
`include "lru_block_buffer_cache_core_defines.svh"
module lbc_ctrl
   import lbc_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SEARCH;
         end
         ST_SEARCH: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (stat.out_free) state_in = req_valid ? ST_SEARCH : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      cmd.search   = 1'b0;
      cmd.commit   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_SEARCH: begin
            cmd.search = 1'b1;
         end
         ST_UPDATE: begin
            cmd.commit = stat.out_free;
            req_ready  = stat.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
      cmd.load_req = req_valid && req_ready;
   end

   `LBC_ASSERT_NOW(a_no_load_in_search, state_ff == ST_SEARCH, !cmd.load_req, "load during search")
   `LBC_ASSERT_NOW(a_commit_out_free, cmd.commit, stat.out_free, "commit with output busy")
   `LBC_ASSERT_NEXT(a_load_to_search, cmd.load_req, state_ff == ST_SEARCH, "load not followed by search")
   `LBC_ASSERT_NEXT(a_commit_to_idle, cmd.commit && !cmd.load_req, state_ff == ST_IDLE, "commit without load not idle")

endmodule
`default_nettype wire

@@ rtl/lbc_dp.sv @@
// Datapath: recency-ordered slot entries, tag search, count update, result register.
// Depends on lbc_pkg. Position p of the entry list holds recency rank p.
`default_nettype none
module lbc_dp
   import lbc_pkg::*;
#(
   parameter int NUM_SLOTS = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cmd_type              cmd,
   output stat_type                  stat,
   input  wire logic [1:0]           req_mode,
   input  wire logic [DEVICE_W-1:0]  req_device,
   input  wire logic [BLOCK_W-1:0]   req_block_number,
   input  wire logic [SLOT_IN_W-1:0] req_slot_in,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [SLOT_IN_W-1:0]      rsp_slot_out,
   output logic                      rsp_hit,
   output logic                      rsp_needs_read,
   output logic [1:0]                rsp_status
);

   localparam int SLOT_W = $clog2(NUM_SLOTS);
   localparam int CMP_W  = (SLOT_W > SLOT_IN_W) ? SLOT_W : SLOT_IN_W;
   localparam int TOP    = NUM_SLOTS - 1;

   // captured request
   mode_type             mode_ff;
   logic [DEVICE_W-1:0]  dev_ff;
   logic [BLOCK_W-1:0]   blk_ff;
   logic [SLOT_IN_W-1:0] slot_ff;

   // entries, ordered by recency
   logic [SLOT_W-1:0]   id_ff      [NUM_SLOTS];
   logic [DEVICE_W-1:0] dev_tag_ff [NUM_SLOTS];
   logic [BLOCK_W-1:0]  blk_tag_ff [NUM_SLOTS];
   logic                valid_ff   [NUM_SLOTS];
   logic [COUNT_W-1:0]  cnt_ff     [NUM_SLOTS];

   // search vectors
   logic [NUM_SLOTS-1:0] match_ff, match_in;
   logic [NUM_SLOTS-1:0] free_ff, free_in;
   logic [NUM_SLOTS-1:0] sel_ff, sel_in;

   // update
   logic [NUM_SLOTS-1:0] rev_match, rev_low, hit_oh, free_oh, tgt, above_mask;
   logic                 hit_any, free_any, sel_any;
   logic [SLOT_W-1:0]    t_id;
   logic [DEVICE_W-1:0]  t_dev;
   logic [BLOCK_W-1:0]   t_blk;
   logic                 t_valid;
   logic [COUNT_W-1:0]   t_cnt;
   logic                 wr_en, retag, move_top, new_valid;
   logic [COUNT_W-1:0]   new_cnt;
   logic [SLOT_IN_W-1:0] res_slot;
   logic                 res_hit, res_rd;
   status_type           res_status;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SLOT_IN_W-1:0] rsp_slot_ff;
   logic                 rsp_hit_ff, rsp_rd_ff;
   status_type           rsp_status_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         mode_ff <= mode_type'(req_mode);
         dev_ff  <= req_device;
         blk_ff  <= req_block_number;
         slot_ff <= req_slot_in;
      end
   end

   always_comb begin
      for (int p = 0; p < NUM_SLOTS; p++) begin
         match_in[p] = (dev_tag_ff[p] == dev_ff) && (blk_tag_ff[p] == blk_ff);
         free_in[p]  = (cnt_ff[p] == '0);
         sel_in[p]   = (CMP_W'(id_ff[p]) == CMP_W'(slot_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.search) begin
         match_ff <= match_in;
         free_ff  <= free_in;
         sel_ff   <= sel_in;
      end
   end

   // highest matching position, lowest free position
   always_comb begin
      for (int p = 0; p < NUM_SLOTS; p++) begin
         rev_match[p] = match_ff[TOP-p];
      end
      rev_low = rev_match & ((~rev_match) + NUM_SLOTS'(1));
      for (int p = 0; p < NUM_SLOTS; p++) begin
         hit_oh[p] = rev_low[TOP-p];
      end
      free_oh  = free_ff & ((~free_ff) + NUM_SLOTS'(1));
      hit_any  = |match_ff;
      free_any = |free_ff;
      sel_any  = |sel_ff;
      if (mode_ff == MODE_GET) begin
         tgt = hit_any ? hit_oh : free_oh;
      end else begin
         tgt = sel_ff;
      end
      above_mask = ~(tgt - NUM_SLOTS'(1));
   end

   always_comb begin
      t_id    = '0;
      t_dev   = '0;
      t_blk   = '0;
      t_valid = 1'b0;
      t_cnt   = '0;
      for (int p = 0; p < NUM_SLOTS; p++) begin
         t_id    = t_id | (id_ff[p] & {SLOT_W{tgt[p]}});
         t_dev   = t_dev | (dev_tag_ff[p] & {DEVICE_W{tgt[p]}});
         t_blk   = t_blk | (blk_tag_ff[p] & {BLOCK_W{tgt[p]}});
         t_valid = t_valid | (valid_ff[p] & tgt[p]);
         t_cnt   = t_cnt | (cnt_ff[p] & {COUNT_W{tgt[p]}});
      end
   end

   always_comb begin
      wr_en      = 1'b0;
      retag      = 1'b0;
      move_top   = 1'b0;
      new_cnt    = t_cnt;
      new_valid  = t_valid;
      res_slot   = slot_ff;
      res_hit    = 1'b0;
      res_rd     = 1'b0;
      res_status = STATUS_OK;
      unique case (mode_ff)
         MODE_GET: begin
            if (hit_any) begin
               res_slot = SLOT_IN_W'(t_id);
               res_hit  = 1'b1;
               if (t_cnt == COUNT_MAX) begin
                  res_status = STATUS_OVERFLOW;
               end else begin
                  wr_en     = 1'b1;
                  new_cnt   = t_cnt + COUNT_W'(1);
                  new_valid = 1'b1;
                  res_rd    = !t_valid;
               end
            end else if (free_any) begin
               res_slot  = SLOT_IN_W'(t_id);
               wr_en     = 1'b1;
               retag     = 1'b1;
               new_cnt   = COUNT_W'(1);
               new_valid = 1'b1;
               res_rd    = 1'b1;
            end else begin
               res_slot   = '0;
               res_status = STATUS_NO_FREE;
            end
         end
         MODE_PIN: begin
            if (sel_any) begin
               if (t_cnt == COUNT_MAX) begin
                  res_status = STATUS_OVERFLOW;
               end else begin
                  wr_en   = 1'b1;
                  new_cnt = t_cnt + COUNT_W'(1);
               end
            end
         end
         MODE_RELEASE, MODE_UNPIN: begin
            if (sel_any) begin
               if (t_cnt == '0) begin
                  res_status = STATUS_UNDERFLOW;
               end else begin
                  wr_en    = 1'b1;
                  new_cnt  = t_cnt - COUNT_W'(1);
                  move_top = (mode_ff == MODE_RELEASE) && (t_cnt == COUNT_W'(1));
               end
            end
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   // release to zero: entries above the target shift down, target goes on top
   for (genvar p = 0; p < NUM_SLOTS; p++) begin : g_pos
      if (p < TOP) begin : g_mid
         always_ff @(posedge clock) begin
            if (reset) begin
               id_ff[p]      <= SLOT_W'(p);
               dev_tag_ff[p] <= '0;
               blk_tag_ff[p] <= '0;
               valid_ff[p]   <= 1'b0;
               cnt_ff[p]     <= '0;
            end else if (cmd.commit) begin
               if (move_top && above_mask[p]) begin
                  id_ff[p]      <= id_ff[p+1];
                  dev_tag_ff[p] <= dev_tag_ff[p+1];
                  blk_tag_ff[p] <= blk_tag_ff[p+1];
                  valid_ff[p]   <= valid_ff[p+1];
                  cnt_ff[p]     <= cnt_ff[p+1];
               end else if (wr_en && tgt[p]) begin
                  valid_ff[p] <= new_valid;
                  cnt_ff[p]   <= new_cnt;
                  if (retag) begin
                     dev_tag_ff[p] <= dev_ff;
                     blk_tag_ff[p] <= blk_ff;
                  end
               end
            end
         end
      end else begin : g_top
         always_ff @(posedge clock) begin
            if (reset) begin
               id_ff[p]      <= SLOT_W'(p);
               dev_tag_ff[p] <= '0;
               blk_tag_ff[p] <= '0;
               valid_ff[p]   <= 1'b0;
               cnt_ff[p]     <= '0;
            end else if (cmd.commit) begin
               if (move_top) begin
                  id_ff[p]      <= t_id;
                  dev_tag_ff[p] <= t_dev;
                  blk_tag_ff[p] <= t_blk;
                  valid_ff[p]   <= new_valid;
                  cnt_ff[p]     <= new_cnt;
               end else if (wr_en && tgt[p]) begin
                  valid_ff[p] <= new_valid;
                  cnt_ff[p]   <= new_cnt;
                  if (retag) begin
                     dev_tag_ff[p] <= dev_ff;
                     blk_tag_ff[p] <= blk_ff;
                  end
               end
            end
         end
      end
   end

   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_slot_ff   <= res_slot;
         rsp_hit_ff    <= res_hit;
         rsp_rd_ff     <= res_rd;
         rsp_status_ff <= res_status;
      end
   end

   assign stat.out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_slot_out   = rsp_slot_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_needs_read = rsp_rd_ff;
   assign rsp_status     = rsp_status_ff;

endmodule
`default_nettype wire

@@ rtl/lru_block_buffer_cache_core.sv @@
// Top level of the buffer cache: joins lbc_ctrl and lbc_dp, types from lbc_pkg.
// A request is captured, its search vectors are registered, then its result is
// committed to the result register. A request is not taken during the search;
// a held result stalls the update step, and the next request is taken as it commits.
// Reset: synchronous; all tags, counts and valid marks clear and
// recency returns to slot index order, with no clearing pass.
`default_nettype none
module lru_block_buffer_cache_core
   import lbc_pkg::*;
#(
   parameter int NUM_SLOTS = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [1:0]           req_mode,
   input  wire logic [DEVICE_W-1:0]  req_device,
   input  wire logic [BLOCK_W-1:0]   req_block_number,
   input  wire logic [SLOT_IN_W-1:0] req_slot_in,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [SLOT_IN_W-1:0]      rsp_slot_out,
   output logic                      rsp_hit,
   output logic                      rsp_needs_read,
   output logic [1:0]                rsp_status
);

   cmd_type  cmd;
   stat_type stat;

   lbc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   lbc_dp #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_mode         (req_mode),
      .req_device       (req_device),
      .req_block_number (req_block_number),
      .req_slot_in      (req_slot_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_slot_out     (rsp_slot_out),
      .rsp_hit          (rsp_hit),
      .rsp_needs_read   (rsp_needs_read),
      .rsp_status       (rsp_status)
   );

endmodule
`default_nettype wire
